// ===== rtl/svtl_pkg.sv =====
// ----------------------------------------------------------------------------
// svtl_pkg: shared types and constants for the strip vertex transform block
// Field widths, command words between front and back, light and color tables.
// ----------------------------------------------------------------------------
`default_nettype none

package svtl_pkg;

	localparam int VERTEX_DEPTH_DEF = 4096;
	localparam int IDX_W      = 12;
	localparam int POS_W      = 24;
	localparam int NRM_W      = 16;
	localparam int CNT_W      = 13;
	localparam int EDGE_W     = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;
	// wide enough to hold the largest vertex depth
	localparam int EXT_W      = 17;
	localparam int QDEPTH     = 4;

	// input opcodes
	typedef enum logic [1:0] {
		OP_WR_VTX = 2'd0,
		OP_WR_NRM = 2'd1,
		OP_STRIP  = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Z     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_SCALE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_COUNT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_EDGE_LIMIT   = 3'd6;

	localparam logic [POS_W-1:0]  VIEW_SCALE_RST = 24'd4096;
	localparam logic [EDGE_W-1:0] EDGE_LIMIT_RST = 48'd14745600;

	// command kinds carried through the queue
	typedef enum logic [1:0] {
		CMD_WR_VTX = 2'd0,
		CMD_WR_NRM = 2'd1,
		CMD_TRI    = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                  kind;
		logic [2:0][IDX_W-1:0]      idx;     // write entry in idx[0]
		logic [2:0]                 nrm_ok;
		logic signed [POS_W-1:0]    vx;
		logic signed [POS_W-1:0]    vy;
		logic signed [POS_W-1:0]    vz;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic signed [POS_W-1:0] cam_x;
		logic signed [POS_W-1:0] cam_y;
		logic signed [POS_W-1:0] cam_z;
		logic [POS_W-1:0]        scale;
		logic [EDGE_W-1:0]       edge_limit;
	} back_cfg_t;

	typedef enum logic [2:0] {
		B_IDLE = 3'd0,
		B_RD   = 3'd1,
		B_EDGE = 3'd2,
		B_CHK  = 3'd3,
		B_MUL  = 3'd4,
		B_FIN  = 3'd5
	} back_state_t;

	// projection and depth constants
	localparam int SX_OFFSET  = 5120 * 65536;
	localparam int SY_OFFSET  = 3584 * 65536;
	localparam int DEPTH_MUL  = 1000;
	localparam int DEPTH_BIAS = 8388607 * 256;

	// normalized light direction, Q.14
	localparam int LIGHT_X = 5070;
	localparam int LIGHT_Y = 11829;
	localparam int LIGHT_Z = 10139;

	// color ramps: base + slope * dot, full at dot >= 1
	localparam logic [7:0] R_BASE = 8'd54;
	localparam logic [7:0] G_BASE = 8'd60;
	localparam logic [7:0] B_BASE = 8'd48;
	localparam int R_SLOPE = 126;
	localparam int G_SLOPE = 140;
	localparam int B_SLOPE = 112;
	localparam logic [7:0] R_FULL = 8'd180;
	localparam logic [7:0] G_FULL = 8'd200;
	localparam logic [7:0] B_FULL = 8'd160;

endpackage

`default_nettype wire

// ===== rtl/svtl_in_if.sv =====
// ----------------------------------------------------------------------------
// svtl_in_if: input item channel
// Valid/ready channel carrying write and strip index items.
// ----------------------------------------------------------------------------
`default_nettype none

interface svtl_in_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          opcode;
	logic [svtl_pkg::IDX_W-1:0]          entry_index;
	logic signed [svtl_pkg::POS_W-1:0]   value_x;
	logic signed [svtl_pkg::POS_W-1:0]   value_y;
	logic signed [svtl_pkg::POS_W-1:0]   value_z;
	logic                                strip_start;

	modport source (output valid, opcode, entry_index, value_x, value_y, value_z,
		strip_start, input ready);
	modport sink (input valid, opcode, entry_index, value_x, value_y, value_z,
		strip_start, output ready);
endinterface

`default_nettype wire

// ===== rtl/svtl_out_if.sv =====
// ----------------------------------------------------------------------------
// svtl_out_if: result item channel
// Valid/ready channel carrying one transformed, lit vertex per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface svtl_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] screen_x;
	logic signed [15:0] screen_y;
	logic [31:0]        depth;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;
	logic               triangle_end;

	modport source (output valid, screen_x, screen_y, depth, red, green, blue,
		triangle_end, input ready);
	modport sink (input valid, screen_x, screen_y, depth, red, green, blue,
		triangle_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/svtl_front.sv =====
// ----------------------------------------------------------------------------
// svtl_front: item intake and strip assembly
// Builds triangles from strip indices, drops degenerate and out-of-range ones,
// and queues memory writes and kept triangles for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module svtl_front #(
	parameter int VERTEX_DEPTH = svtl_pkg::VERTEX_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	svtl_in_if.sink                       in_ch,
	input  logic [svtl_pkg::CNT_W-1:0]    vertex_count,
	input  logic [svtl_pkg::CNT_W-1:0]    normal_count,
	input  svtl_pkg::q_status_t           q_stat,
	output logic                          q_push,
	output svtl_pkg::cmd_t                q_cmd
);
	import svtl_pkg::*;

	localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(VERTEX_DEPTH);

	logic [IDX_W-1:0]      older_q, newer_q;
	logic [1:0]            fill_q;
	logic                  odd_q;
	logic                  acc;
	logic [1:0]            fill_eff;
	logic                  odd_eff;
	logic                  tri_pos;
	logic                  degen;
	logic                  in_rng;
	logic                  wr_ok;
	logic [2:0][IDX_W-1:0] tri_idx;
	opcode_t               op;

	function automatic logic idx_ok(input logic [IDX_W-1:0] i,
		input logic [CNT_W-1:0] cnt);
		return (CNT_W'(i) < cnt) && (EXT_W'(i) < DEPTH_EXT);
	endfunction

	assign in_ch.ready = !q_stat.full;
	assign acc = in_ch.valid && in_ch.ready;
	assign op = opcode_t'(in_ch.opcode);

	// strip position and triangle checks
	always_comb begin
		fill_eff = in_ch.strip_start ? 2'd0 : fill_q;
		odd_eff  = in_ch.strip_start ? 1'b0 : odd_q;
		tri_pos  = (fill_eff == 2'd2);
		degen    = (older_q == newer_q) || (newer_q == in_ch.entry_index)
			|| (older_q == in_ch.entry_index);
		tri_idx[0] = older_q;
		tri_idx[1] = odd_eff ? in_ch.entry_index : newer_q;
		tri_idx[2] = odd_eff ? newer_q : in_ch.entry_index;
		in_rng = idx_ok(tri_idx[0], vertex_count) && idx_ok(tri_idx[1], vertex_count)
			&& idx_ok(tri_idx[2], vertex_count);
		wr_ok  = (EXT_W'(in_ch.entry_index) < DEPTH_EXT);
	end

	// command build
	always_comb begin
		q_cmd.idx       = tri_idx;
		q_cmd.nrm_ok[0] = idx_ok(tri_idx[0], normal_count);
		q_cmd.nrm_ok[1] = idx_ok(tri_idx[1], normal_count);
		q_cmd.nrm_ok[2] = idx_ok(tri_idx[2], normal_count);
		q_cmd.vx        = in_ch.value_x;
		q_cmd.vy        = in_ch.value_y;
		q_cmd.vz        = in_ch.value_z;
		case (op)
			OP_WR_VTX: begin
				q_cmd.kind   = CMD_WR_VTX;
				q_cmd.idx[0] = in_ch.entry_index;
				q_push       = acc && wr_ok;
			end
			OP_WR_NRM: begin
				q_cmd.kind   = CMD_WR_NRM;
				q_cmd.idx[0] = in_ch.entry_index;
				q_push       = acc && wr_ok;
			end
			OP_STRIP: begin
				q_cmd.kind = CMD_TRI;
				q_push     = acc && tri_pos && !degen && in_rng;
			end
			default: begin
				q_cmd.kind = CMD_TRI;
				q_push     = 1'b0;
			end
		endcase
	end

	// strip state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q <= '0;
			newer_q <= '0;
			fill_q  <= '0;
			odd_q   <= 1'b0;
		end else if (acc && op == OP_STRIP) begin
			older_q <= newer_q;
			newer_q <= in_ch.entry_index;
			fill_q  <= tri_pos ? 2'd2 : fill_eff + 2'd1;
			odd_q   <= tri_pos ? !odd_eff : odd_eff;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/svtl_fifo.sv =====
// ----------------------------------------------------------------------------
// svtl_fifo: command queue between front and back
// Small register queue that lets either side stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module svtl_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  svtl_pkg::cmd_t      cmd_in,
	input  logic                pop,
	output svtl_pkg::cmd_t      cmd_out,
	output svtl_pkg::q_status_t stat
);
	import svtl_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	cmd_t              entry_q [QDEPTH];
	logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [PW:0]       count_q;

	assign stat.full  = (count_q == (PW+1)'(QDEPTH));
	assign stat.empty = (count_q == '0);
	assign cmd_out    = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/svtl_back.sv =====
// ----------------------------------------------------------------------------
// svtl_back: memories, edge test, transform and lighting
// Executes queued writes, fetches triangle vertices, tests edge lengths and
// emits the three projected, shaded vertices of a kept triangle one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module svtl_back #(
	parameter int VERTEX_DEPTH = svtl_pkg::VERTEX_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  svtl_pkg::q_status_t q_stat,
	input  svtl_pkg::cmd_t      q_cmd,
	output logic                q_pop,
	input  svtl_pkg::back_cfg_t cfg,
	svtl_out_if.source          out_ch
);
	import svtl_pkg::*;

	localparam int AW  = $clog2(VERTEX_DEPTH);
	localparam int SQW = 50;
	localparam int ESW = 52;
	localparam int PW  = 50;
	localparam int TW  = 51;
	localparam int ZW  = 37;
	localparam int DW  = 33;
	localparam logic signed [TW-1:0] SX_OFF = TW'(SX_OFFSET);
	localparam logic signed [TW-1:0] SY_OFF = TW'(SY_OFFSET);
	localparam logic signed [ZW-1:0] Z_BIAS = ZW'(DEPTH_BIAS);
	localparam logic signed [DW-1:0] DOT_ONE = DW'(1) <<< 28;

	// vertex memories
	logic signed [POS_W-1:0] px_mem [VERTEX_DEPTH];
	logic signed [POS_W-1:0] py_mem [VERTEX_DEPTH];
	logic signed [POS_W-1:0] pz_mem [VERTEX_DEPTH];
	logic signed [NRM_W-1:0] nx_mem [VERTEX_DEPTH];
	logic signed [NRM_W-1:0] ny_mem [VERTEX_DEPTH];
	logic signed [NRM_W-1:0] nz_mem [VERTEX_DEPTH];

	back_state_t             state_q, state_d;
	logic [1:0]              cnt_q;
	cmd_t                    cmd_q;
	logic                    pos_we, nrm_we, out_load, out_free;
	logic [AW-1:0]           wr_addr, rd_addr;
	logic signed [POS_W-1:0] px_rd_q, py_rd_q, pz_rd_q;
	logic signed [NRM_W-1:0] nx_rd_q, ny_rd_q, nz_rd_q;
	logic signed [POS_W-1:0] vx_q [3];
	logic signed [POS_W-1:0] vy_q [3];
	logic signed [POS_W-1:0] vz_q [3];
	logic signed [NRM_W-1:0] nx_q [3];
	logic signed [NRM_W-1:0] ny_q [3];
	logic signed [NRM_W-1:0] nz_q [3];

	// edge test
	logic signed [POS_W-1:0] ea_x, ea_y, ea_z, eb_x, eb_y, eb_z;
	logic signed [POS_W:0]   ed_x, ed_y, ed_z;
	logic [SQW-1:0]          sqx_q, sqy_q, sqz_q;
	logic [ESW-1:0]          esum, emax_q;

	// transform and lighting
	logic signed [POS_W-1:0] sel_x, sel_y, sel_z;
	logic signed [NRM_W-1:0] sel_nx, sel_ny, sel_nz;
	logic                    sel_nok;
	logic signed [POS_W:0]   dx, dy, dz;
	logic signed [PW-1:0]    mx_q, my_q;
	logic signed [ZW-1:0]    mz_q;
	logic signed [30:0]      lx_q, ly_q, lz_q;
	logic                    nok_q;
	logic signed [TW-1:0]    sxw, syw;
	logic signed [ZW-1:0]    tzw;
	logic signed [DW-1:0]    dot;
	logic [35:0]             pr, pg, pb;
	logic signed [15:0]      sx_v, sy_v;
	logic [31:0]             depth_v;
	logic [7:0]              r_v, g_v, b_v;

	// output register
	logic                    out_v_q;
	logic signed [15:0]      sx_q, sy_q;
	logic [31:0]             depth_q;
	logic [7:0]              r_q, g_q, b_q;
	logic                    tend_q;

	function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] i);
		logic [EXT_W-1:0] e;
		e = EXT_W'(i);
		return e[AW-1:0];
	endfunction

	// signed truncating divide by 2^16, then clamp to int16
	function automatic logic signed [15:0] div_sat(input logic signed [TW-1:0] v);
		logic signed [TW-1:0] q;
		q = v >>> 16;
		if (v < 0 && v[15:0] != '0) begin
			q = q + TW'(1);
		end
		if (q > TW'(32767)) begin
			return 16'sh7FFF;
		end else if (q < -TW'(32768)) begin
			return 16'sh8000;
		end
		return q[15:0];
	endfunction

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!q_stat.empty && q_cmd.kind == CMD_TRI) begin
					state_d = B_RD;
				end
			end
			B_RD: begin
				if (cnt_q == 2'd3) begin
					state_d = B_EDGE;
				end
			end
			B_EDGE: begin
				if (cnt_q == 2'd3) begin
					state_d = B_CHK;
				end
			end
			B_CHK: begin
				state_d = (emax_q > ESW'(cfg.edge_limit)) ? B_IDLE : B_MUL;
			end
			B_MUL: begin
				state_d = B_FIN;
			end
			B_FIN: begin
				if (out_free) begin
					state_d = (cnt_q == 2'd2) ? B_IDLE : B_MUL;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		q_pop    = 1'b0;
		pos_we   = 1'b0;
		nrm_we   = 1'b0;
		out_load = 1'b0;
		rd_addr  = to_addr(cmd_q.idx[0]);
		case (state_q)
			B_IDLE: begin
				q_pop  = !q_stat.empty;
				pos_we = !q_stat.empty && q_cmd.kind == CMD_WR_VTX;
				nrm_we = !q_stat.empty && q_cmd.kind == CMD_WR_NRM;
			end
			B_RD: begin
				case (cnt_q)
					2'd1:    rd_addr = to_addr(cmd_q.idx[1]);
					2'd2:    rd_addr = to_addr(cmd_q.idx[2]);
					default: rd_addr = to_addr(cmd_q.idx[0]);
				endcase
			end
			B_FIN: begin
				out_load = out_free;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	assign wr_addr  = to_addr(q_cmd.idx[0]);
	assign out_free = !out_v_q || out_ch.ready;

	// memories, one write and one registered read port each
	always_ff @(posedge clk) begin
		if (pos_we) begin
			px_mem[wr_addr] <= q_cmd.vx;
			py_mem[wr_addr] <= q_cmd.vy;
			pz_mem[wr_addr] <= q_cmd.vz;
		end
		px_rd_q <= px_mem[rd_addr];
		py_rd_q <= py_mem[rd_addr];
		pz_rd_q <= pz_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (nrm_we) begin
			nx_mem[wr_addr] <= q_cmd.vx[NRM_W-1:0];
			ny_mem[wr_addr] <= q_cmd.vy[NRM_W-1:0];
			nz_mem[wr_addr] <= q_cmd.vz[NRM_W-1:0];
		end
		nx_rd_q <= nx_mem[rd_addr];
		ny_rd_q <= ny_mem[rd_addr];
		nz_rd_q <= nz_mem[rd_addr];
	end

	// edge pair selection: (0,1), (1,2), (0,2)
	always_comb begin
		case (cnt_q)
			2'd1: begin
				ea_x = vx_q[1]; ea_y = vy_q[1]; ea_z = vz_q[1];
				eb_x = vx_q[2]; eb_y = vy_q[2]; eb_z = vz_q[2];
			end
			2'd2: begin
				ea_x = vx_q[0]; ea_y = vy_q[0]; ea_z = vz_q[0];
				eb_x = vx_q[2]; eb_y = vy_q[2]; eb_z = vz_q[2];
			end
			default: begin
				ea_x = vx_q[0]; ea_y = vy_q[0]; ea_z = vz_q[0];
				eb_x = vx_q[1]; eb_y = vy_q[1]; eb_z = vz_q[1];
			end
		endcase
		ed_x = (POS_W+1)'(ea_x) - (POS_W+1)'(eb_x);
		ed_y = (POS_W+1)'(ea_y) - (POS_W+1)'(eb_y);
		ed_z = (POS_W+1)'(ea_z) - (POS_W+1)'(eb_z);
		esum = ESW'(sqx_q) + ESW'(sqy_q) + ESW'(sqz_q);
	end

	// vertex selection for the transform
	always_comb begin
		case (cnt_q)
			2'd1: begin
				sel_x = vx_q[1]; sel_y = vy_q[1]; sel_z = vz_q[1];
				sel_nx = nx_q[1]; sel_ny = ny_q[1]; sel_nz = nz_q[1];
				sel_nok = cmd_q.nrm_ok[1];
			end
			2'd2: begin
				sel_x = vx_q[2]; sel_y = vy_q[2]; sel_z = vz_q[2];
				sel_nx = nx_q[2]; sel_ny = ny_q[2]; sel_nz = nz_q[2];
				sel_nok = cmd_q.nrm_ok[2];
			end
			default: begin
				sel_x = vx_q[0]; sel_y = vy_q[0]; sel_z = vz_q[0];
				sel_nx = nx_q[0]; sel_ny = ny_q[0]; sel_nz = nz_q[0];
				sel_nok = cmd_q.nrm_ok[0];
			end
		endcase
		dx = (POS_W+1)'(sel_x) - (POS_W+1)'(cfg.cam_x);
		dy = (POS_W+1)'(sel_y) - (POS_W+1)'(cfg.cam_y);
		dz = (POS_W+1)'(sel_z) - (POS_W+1)'(cfg.cam_z);
	end

	// final stage: offsets, truncation, saturation, shading
	always_comb begin
		sxw     = TW'(mx_q) + SX_OFF;
		syw     = SY_OFF - TW'(my_q);
		tzw     = mz_q + Z_BIAS;
		sx_v    = div_sat(sxw);
		sy_v    = div_sat(syw);
		depth_v = (tzw < 0) ? 32'd0 : 32'(tzw[ZW-2:8]);
		dot     = DW'(lx_q) + DW'(ly_q) + DW'(lz_q);
		pr      = 36'(dot[27:0]) * 36'(R_SLOPE);
		pg      = 36'(dot[27:0]) * 36'(G_SLOPE);
		pb      = 36'(dot[27:0]) * 36'(B_SLOPE);
		r_v     = R_BASE;
		g_v     = G_BASE;
		b_v     = B_BASE;
		if (nok_q) begin
			if (dot >= DOT_ONE) begin
				r_v = R_FULL;
				g_v = G_FULL;
				b_v = B_FULL;
			end else if (dot > 0) begin
				r_v = R_BASE + 8'(pr >> 28);
				g_v = G_BASE + 8'(pg >> 28);
				b_v = B_BASE + 8'(pb >> 28);
			end
		end
	end

	// sequencer state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				B_RD, B_EDGE: cnt_q <= (cnt_q == 2'd3) ? 2'd0 : cnt_q + 2'd1;
				B_FIN: begin
					if (out_free) begin
						cnt_q <= cnt_q + 2'd1;
					end
				end
				B_IDLE, B_CHK: cnt_q <= 2'd0;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE) begin
			cmd_q <= q_cmd;
		end
		if (state_q == B_RD && cnt_q != 2'd0) begin
			vx_q[cnt_q - 2'd1] <= px_rd_q;
			vy_q[cnt_q - 2'd1] <= py_rd_q;
			vz_q[cnt_q - 2'd1] <= pz_rd_q;
			nx_q[cnt_q - 2'd1] <= nx_rd_q;
			ny_q[cnt_q - 2'd1] <= ny_rd_q;
			nz_q[cnt_q - 2'd1] <= nz_rd_q;
		end
		if (state_q == B_EDGE) begin
			sqx_q <= SQW'(ed_x * ed_x);
			sqy_q <= SQW'(ed_y * ed_y);
			sqz_q <= SQW'(ed_z * ed_z);
			if (cnt_q == 2'd1) begin
				emax_q <= esum;
			end else if (cnt_q != 2'd0 && esum > emax_q) begin
				emax_q <= esum;
			end
		end
		if (state_q == B_MUL) begin
			mx_q  <= PW'(dx * $signed({1'b0, cfg.scale}));
			my_q  <= PW'(dy * $signed({1'b0, cfg.scale}));
			mz_q  <= ZW'(dz * $signed(11'(DEPTH_MUL)));
			lx_q  <= 31'(sel_nx * $signed(15'(LIGHT_X)));
			ly_q  <= 31'(sel_ny * $signed(15'(LIGHT_Y)));
			lz_q  <= 31'(sel_nz * $signed(15'(LIGHT_Z)));
			nok_q <= sel_nok;
		end
		if (out_load) begin
			sx_q    <= sx_v;
			sy_q    <= sy_v;
			depth_q <= depth_v;
			r_q     <= r_v;
			g_q     <= g_v;
			b_q     <= b_v;
			tend_q  <= (cnt_q == 2'd2);
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	assign out_ch.valid        = out_v_q;
	assign out_ch.screen_x     = sx_q;
	assign out_ch.screen_y     = sy_q;
	assign out_ch.depth        = depth_q;
	assign out_ch.red          = r_q;
	assign out_ch.green        = g_q;
	assign out_ch.blue         = b_q;
	assign out_ch.triangle_end = tend_q;

endmodule

`default_nettype wire

// ===== rtl/strip_vertex_transform_light.sv =====
// ----------------------------------------------------------------------------
// strip_vertex_transform_light: strip vertex transform with Lambert lighting
// Loads positions and normals, assembles strip triangles, culls them and
// emits orthographically projected, shaded vertices.
// ----------------------------------------------------------------------------
//   channel   dir  handshake     content
//   in_ch     in   valid/ready   opcode, entry_index, value_x/y/z, strip_start
//   out_ch    out  valid/ready   screen_x/y, depth, red/green/blue, triangle_end
//   cfg_*     in   cfg_we only   cfg_index selects register, cfg_data value
//
// The front takes one item per cycle while the 4-entry command queue has room.
// The back takes a write as it pops it. A kept triangle goes through the pop,
// memory fetch, edge test and cull decision, then a multiply and a finish step
// per vertex emitted; one dropped by the edge test frees the back at that decision.
// Items that make no command (first indices, degenerate, out of range, unused)
// cost the front only.
// Reset clears control state; memories are undefined until written.
// A stalled output holds the back sequencer; the front keeps filling the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module strip_vertex_transform_light #(
	parameter int VERTEX_DEPTH = svtl_pkg::VERTEX_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	svtl_in_if.sink                           in_ch,
	svtl_out_if.source                        out_ch,
	input  logic                              cfg_we,
	input  logic [svtl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [svtl_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import svtl_pkg::*;

	logic [CNT_W-1:0] vertex_count_q, normal_count_q;
	back_cfg_t        cfg_q;
	logic             q_push, q_pop;
	cmd_t             push_cmd, head_cmd;
	q_status_t        q_stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cam_x      <= '0;
			cfg_q.cam_y      <= '0;
			cfg_q.cam_z      <= '0;
			cfg_q.scale      <= VIEW_SCALE_RST;
			cfg_q.edge_limit <= EDGE_LIMIT_RST;
			vertex_count_q   <= '0;
			normal_count_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CAMERA_X:     cfg_q.cam_x      <= cfg_data[POS_W-1:0];
				CFG_CAMERA_Y:     cfg_q.cam_y      <= cfg_data[POS_W-1:0];
				CFG_CAMERA_Z:     cfg_q.cam_z      <= cfg_data[POS_W-1:0];
				CFG_VIEW_SCALE:   cfg_q.scale      <= cfg_data[POS_W-1:0];
				CFG_VERTEX_COUNT: vertex_count_q   <= cfg_data[CNT_W-1:0];
				CFG_NORMAL_COUNT: normal_count_q   <= cfg_data[CNT_W-1:0];
				CFG_EDGE_LIMIT:   cfg_q.edge_limit <= cfg_data[EDGE_W-1:0];
				default:          cfg_q            <= cfg_q;
			endcase
		end
	end

	svtl_front #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_ch        (in_ch),
		.vertex_count (vertex_count_q),
		.normal_count (normal_count_q),
		.q_stat       (q_stat),
		.q_push       (q_push),
		.q_cmd        (push_cmd)
	);

	svtl_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.cmd_in  (push_cmd),
		.pop     (q_pop),
		.cmd_out (head_cmd),
		.stat    (q_stat)
	);

	svtl_back #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_stat (q_stat),
		.q_cmd  (head_cmd),
		.q_pop  (q_pop),
		.cfg    (cfg_q),
		.out_ch (out_ch)
	);

	// queue integrity
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full) else $error("command pushed into full queue");
	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty) else $error("command popped from empty queue");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !in_ch.ready) else $error("input ready while queue full");

endmodule

`default_nettype wire
